@@ src/gfmi_pkg.sv @@
// Shared types, codes and GF(2^8) helper functions for the field arithmetic unit.
package gfmi_pkg;

   localparam logic       KIND_MUL  = 1'b0;
   localparam logic       KIND_INV  = 1'b1;
   localparam logic [7:0] GF_REDUCE = 8'h1B;
   localparam logic [7:0] GF_ONE    = 8'h01;

   typedef logic [7:0] elem_type;

   // Payload carried between pipeline stages.
   typedef struct packed {
      logic     kind;
      elem_type a;
      elem_type a3;
      elem_type acc;
   } stage_type;

   // Carry-less multiply reduced by x^8+x^4+x^3+x+1.
   function automatic elem_type gf_mul(input elem_type x, input elem_type y);
      elem_type acc;
      elem_type sh;
      acc = '0;
      sh  = x;
      for (int i = 0; i < 8; i++) begin
         if (y[i]) begin
            acc = acc ^ sh;
         end
         sh = sh[7] ? ({sh[6:0], 1'b0} ^ GF_REDUCE) : {sh[6:0], 1'b0};
      end
      return acc;
   endfunction

   // Squaring is linear over GF(2); synthesis folds it into an XOR network.
   function automatic elem_type gf_sq(input elem_type x);
      return gf_mul(x, x);
   endfunction

endpackage

@@ src/gfmi_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface gfmi_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] operand_a;
   logic [7:0] operand_b;

   modport source (output valid, kind, operand_a, operand_b, input ready);
   modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface gfmi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] field_result;

   modport source (output valid, field_result, input ready);
   modport sink   (input valid, field_result, output ready);
endinterface

@@ src/gfmi_stage.sv @@
// One pipeline stage: a field multiplier feeding a registered payload with its valid bit.
module gfmi_stage
   import gfmi_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   input  elem_type  mul_x,
   input  elem_type  mul_y,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;

   // Take a new item when empty or when the held one leaves this cycle.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in     = in_data;
      data_in.acc = gf_mul(mul_x, mul_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ src/gf256_multiply_inverse.sv @@
// Pipeline of registered stages, one multiplier per stage; the response comes from the last stage register.
// Throughput: one item per cycle; each stage stalls only when it is full and blocked.
// Inverse is a^254 by the chain a^3, a^15, a^63, then a^63^4 * a^2 (zero maps to zero).
// Product needs only the first multiplier; later stages multiply it by one.
// Reset (synchronous, active high) clears all stage valid bits; payload is not reset.
module gf256_multiply_inverse
   import gfmi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   gfmi_req_if.sink    req_chan,
   gfmi_rsp_if.source  rsp_chan
);

   localparam int NumStages = 4;

   logic      stg_in_valid [NumStages];
   logic      stg_in_ready [NumStages];
   logic      stg_out_valid[NumStages];
   logic      stg_out_ready[NumStages];
   stage_type stg_in_data  [NumStages];
   stage_type stg_out_data [NumStages];
   elem_type  stg_mul_x    [NumStages];
   elem_type  stg_mul_y    [NumStages];

   // Load stage 1 from the request; the a^3 slot is filled after stage 1.
   always_comb begin
      stg_in_data[0].kind = req_chan.kind;
      stg_in_data[0].a    = req_chan.operand_a;
      stg_in_data[0].a3   = req_chan.operand_a;
      stg_in_data[0].acc  = '0;
      if (req_chan.kind == KIND_INV) begin
         stg_mul_x[0] = gf_sq(req_chan.operand_a);    // a^2 * a = a^3
         stg_mul_y[0] = req_chan.operand_a;
      end else begin
         stg_mul_x[0] = req_chan.operand_a;           // a * b
         stg_mul_y[0] = req_chan.operand_b;
      end
   end

   // Stage 2: capture a^3, form a^12 * a^3 = a^15.
   always_comb begin
      stg_in_data[1]    = stg_out_data[0];
      stg_in_data[1].a3 = stg_out_data[0].acc;
      if (stg_out_data[0].kind == KIND_INV) begin
         stg_mul_x[1] = gf_sq(gf_sq(stg_out_data[0].acc));
         stg_mul_y[1] = stg_out_data[0].acc;
      end else begin
         stg_mul_x[1] = stg_out_data[0].acc;
         stg_mul_y[1] = GF_ONE;
      end
   end

   // Stage 3: a^60 * a^3 = a^63.
   always_comb begin
      stg_in_data[2] = stg_out_data[1];
      if (stg_out_data[1].kind == KIND_INV) begin
         stg_mul_x[2] = gf_sq(gf_sq(stg_out_data[1].acc));
         stg_mul_y[2] = stg_out_data[1].a3;
      end else begin
         stg_mul_x[2] = stg_out_data[1].acc;
         stg_mul_y[2] = GF_ONE;
      end
   end

   // Stage 4: a^252 * a^2 = a^254, the inverse.
   always_comb begin
      stg_in_data[3] = stg_out_data[2];
      if (stg_out_data[2].kind == KIND_INV) begin
         stg_mul_x[3] = gf_sq(gf_sq(stg_out_data[2].acc));
         stg_mul_y[3] = gf_sq(stg_out_data[2].a);
      end else begin
         stg_mul_x[3] = stg_out_data[2].acc;
         stg_mul_y[3] = GF_ONE;
      end
   end

   // Chain valid/ready between stages; backpressure ripples only through full stages.
   assign stg_in_valid[0] = req_chan.valid;
   assign req_chan.ready  = stg_in_ready[0];

   for (genvar s = 0; s < NumStages; s++) begin : g_stage
      if (s > 0) begin : g_link
         assign stg_in_valid[s]    = stg_out_valid[s-1];
         assign stg_out_ready[s-1] = stg_in_ready[s];
      end

      gfmi_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_in_valid[s]),
         .in_ready  (stg_in_ready[s]),
         .in_data   (stg_in_data[s]),
         .mul_x     (stg_mul_x[s]),
         .mul_y     (stg_mul_y[s]),
         .out_valid (stg_out_valid[s]),
         .out_ready (stg_out_ready[s]),
         .out_data  (stg_out_data[s])
      );
   end

   // Drive the response straight from the last stage register.
   assign stg_out_ready[NumStages-1] = rsp_chan.ready;
   assign rsp_chan.valid             = stg_out_valid[NumStages-1];
   assign rsp_chan.field_result      = stg_out_data[NumStages-1].acc;

   // A nonzero element times its inverse must be one.
   a_inv_exact: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && stg_out_data[NumStages-1].kind == KIND_INV
       && stg_out_data[NumStages-1].a != 8'h00)
      |-> gf_mul(rsp_chan.field_result, stg_out_data[NumStages-1].a) == GF_ONE)
      else $error("inverse times operand is not one");

   // Zero has no inverse and must map to zero.
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && stg_out_data[NumStages-1].kind == KIND_INV
       && stg_out_data[NumStages-1].a == 8'h00)
      |-> rsp_chan.field_result == 8'h00)
      else $error("inverse of zero is not zero");

   // An accepted request always lands in the first stage on the next edge.
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> stg_out_valid[0])
      else $error("accepted item missing from first stage");

endmodule

@@ tb/tb_gf256_multiply_inverse.sv @@
// Testbench for the GF(2^8) multiply/inverse unit: directed and random items, scoreboard check.
module tb_gf256_multiply_inverse
   import gfmi_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS  = 550;
   localparam int MAX_WAIT      = 14;
   localparam int DRAIN_CYCLES  = 20;   // well past the four-stage pipeline
   localparam int RESET_CYCLES  = 8;

   // Expected field results in arrival order, plus the arithmetic that makes them.
   class gf_result_checker;
      elem_type pending_results[$];
      int       failures;

      // Schoolbook carry-less product, then fold bits 14..8 back with x^8+x^4+x^3+x+1.
      function elem_type product(elem_type x, elem_type y);
         logic [14:0] wide;
         wide = '0;
         for (int i = 0; i < 8; i++) begin
            if (y[i]) begin
               wide = wide ^ (15'(x) << i);
            end
         end
         for (int j = 14; j >= 8; j--) begin
            if (wide[j]) begin
               wide = wide ^ (15'({1'b1, GF_REDUCE}) << (j - 8));
            end
         end
         return wide[7:0];
      endfunction

      // Search the whole field for the element whose product with x is one.
      function elem_type inverse(elem_type x);
         elem_type found;
         found = '0;
         if (x != '0) begin
            for (int c = 1; c < 256; c++) begin
               if (product(x, elem_type'(c)) == GF_ONE) begin
                  found = elem_type'(c);
               end
            end
         end
         return found;
      endfunction

      function void note_request(logic kind, elem_type a, elem_type b);
         if (kind == KIND_INV) begin
            pending_results.push_back(inverse(a));
         end else begin
            pending_results.push_back(product(a, b));
         end
      endfunction

      function void check_result(elem_type actual);
         elem_type want;
         if (pending_results.size() == 0) begin
            $error("field_result %02h arrived with no item outstanding", actual);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (actual !== want) begin
               $error("field_result mismatch: expected %02h actual %02h", want, actual);
               failures++;
            end
         end
      endfunction

      function void check_leftovers();
         if (pending_results.size() != 0) begin
            $error("field_result: %0d items never answered", pending_results.size());
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   gfmi_req_if req_bus();
   gfmi_rsp_if rsp_bus();

   gf_result_checker board;

   bit send_steady;   // sender runs back to back while set
   bit recv_steady;   // receiver never stalls while set

   gf256_multiply_inverse DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Favor the field's edge elements now and then, otherwise any byte.
   function automatic elem_type pick_element();
      elem_type edges[4];
      edges = '{8'h00, 8'h01, 8'h80, 8'hFF};
      if ($urandom_range(0, 7) == 0) begin
         return edges[$urandom_range(0, 3)];
      end
      return elem_type'($urandom_range(0, 255));
   endfunction

   // Present one item after an optional gap and hold it until the unit takes it.
   // Called at a rising edge; returns at the edge where the item was accepted.
   task automatic send_item(input logic kind, input elem_type a, input elem_type b);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.operand_a <= a;
      req_bus.operand_b <= b;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(kind, a, b);
   endtask

   // Drop valid and hold until every outstanding result has come back.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
   endtask

   // Accept results forever, dropping ready for a random stall before each one unless recv_steady is set.
   task automatic collect_results();
      int stall;
      int taken;
      taken = 0;
      forever begin
         if (taken % 40 == 0) begin
            recv_steady = ($urandom_range(0, 3) == 0);
         end
         stall = recv_steady ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         board.check_result(rsp_bus.field_result);
         taken++;
      end
   endtask

   // Hard stop in case a handshake never completes.
   initial begin
      #2_000_000;
      $display("** gf256_multiply_inverse: FAILED **");
      $finish;
   end

   initial begin
      board = new;
      send_steady = 1'b0;
      recv_steady = 1'b0;

      // Drive every input to a known value from time zero.
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.kind      <= KIND_MUL;
      req_bus.operand_a <= '0;
      req_bus.operand_b <= '0;
      rsp_bus.ready     <= 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      fork
         collect_results();
      join_none

      // Directed products: zero factors, all-ones, identity, reduction on overflow,
      // and known textbook pairs.
      send_item(KIND_MUL, 8'h00, 8'h00);
      send_item(KIND_MUL, 8'h00, 8'hFF);
      send_item(KIND_MUL, 8'hFF, 8'h00);
      send_item(KIND_MUL, 8'hFF, 8'hFF);
      send_item(KIND_MUL, 8'h01, 8'hA5);
      send_item(KIND_MUL, 8'h5A, 8'h01);
      send_item(KIND_MUL, 8'h80, 8'h02);
      send_item(KIND_MUL, 8'h80, 8'h80);
      send_item(KIND_MUL, 8'h57, 8'h83);
      send_item(KIND_MUL, 8'h53, 8'hCA);

      // Directed inverses: zero maps to zero, operand_b must not matter.
      send_item(KIND_INV, 8'h00, 8'hFF);
      send_item(KIND_INV, 8'h00, 8'h00);
      send_item(KIND_INV, 8'h01, 8'h00);
      send_item(KIND_INV, 8'h01, 8'hFF);
      send_item(KIND_INV, 8'hFF, 8'h5A);
      send_item(KIND_INV, 8'h80, 8'hA5);
      send_item(KIND_INV, 8'h53, 8'h00);
      send_item(KIND_INV, 8'h02, 8'hFF);
      send_item(KIND_INV, 8'h03, 8'h01);

      // Let the pipeline empty completely before the random part.
      wait_for_drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Re-draw the sender's pacing every so often so back-to-back runs appear.
         if (n % 50 == 0) begin
            send_steady = ($urandom_range(0, 2) == 0);
         end
         // Halfway through, pause once more until everything is answered.
         if (n == RANDOM_ITEMS / 2) begin
            wait_for_drain();
         end
         send_item($urandom_range(0, 1) ? KIND_INV : KIND_MUL, pick_element(), pick_element());
      end
      req_bus.valid <= 1'b0;

      // Wait for the last results, then watch a while for anything extra.
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.check_leftovers();

      if (board.failures == 0) begin
         $display("** gf256_multiply_inverse: PASSED **");
      end else begin
         $display("** gf256_multiply_inverse: FAILED **");
      end
      $finish;
   end

endmodule
